// File: rtl/medf3_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; every other file except medf3_ram imports this package.
package medf3_pkg;

  localparam int KERNEL       = 3;
  localparam int PIX_W        = 8;
  localparam int BANK_W       = $clog2(KERNEL);
  localparam int ROW_W        = 12;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int MAX_HEIGHT   = 4096;

  localparam int IMAGE_WIDTH_RESET  = 640;
  localparam int IMAGE_HEIGHT_RESET = 480;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [BANK_W-1:0] bank_t;
  typedef pix_t [KERNEL-1:0] trio_t;   // one window column, or one sorted column
  typedef trio_t [KERNEL-1:0] win_t;   // three columns: left, center, right

  typedef struct packed {
    pix_t pixel_in;
    logic drain;
  } in_word_t;

  typedef struct packed {
    pix_t pixel_out;
    logic end_of_row;
    logic end_of_frame;
  } out_word_t;

  // Line store write request for the current word
  typedef struct packed {
    logic  wr_en;
    bank_t wr_bank;
    pix_t  pixel;
  } wr_ctl_t;

  // Result request: which banks feed the top, middle and bottom window rows
  typedef struct packed {
    logic                   emit;
    logic                   first_col;
    logic                   end_of_row;
    logic                   end_of_frame;
    bank_t [KERNEL-1:0]     row_bank;
  } emit_ctl_t;

  function automatic bank_t bank_inc(bank_t b);
    return (b == bank_t'(KERNEL - 1)) ? '0 : bank_t'(b + 1'b1);
  endfunction

  function automatic bank_t bank_dec(bank_t b);
    return (b == '0) ? bank_t'(KERNEL - 1) : bank_t'(b - 1'b1);
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Sort one column: [0] lowest, [1] middle, [2] highest
  function automatic trio_t sort3(trio_t v);
    pix_t a;
    pix_t b;
    pix_t c;
    pix_t t;
    a = v[0];
    b = v[1];
    c = v[2];
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (b > c) begin
      t = b; b = c; c = t;
    end
    if (a > b) begin
      t = a; a = b; b = t;
    end
    return {c, b, a};
  endfunction

endpackage

// File: rtl/medf3_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data with enable.
// Standalone; no package needed.
module medf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/medf3_ctrl.sv
`timescale 1ns / 1ps
// Frame geometry registers, input/output raster counters and result readiness.
// Depends on medf3_pkg.
module medf3_ctrl #(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [medf3_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [medf3_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                step,
  input  logic                                drain,
  input  medf3_pkg::pix_t                     pixel,
  output medf3_pkg::wr_ctl_t                  wr,
  output logic [CW-1:0]                       wr_col,
  output logic [CW-1:0]                       rd_col_a,
  output logic [CW-1:0]                       rd_col_b,
  output medf3_pkg::emit_ctl_t                rd
);
  import medf3_pkg::*;

  localparam int W_RST = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;
  localparam logic [CW-1:0]        W_LAST_RST = CW'(W_RST - 1);
  localparam logic [ROW_W-1:0]     H_LAST_RST = ROW_W'(IMAGE_HEIGHT_RESET - 1);
  localparam logic [WIDTH_REG_W:0] MAXW_CMP   = (WIDTH_REG_W + 1)'(MAX_WIDTH);
  localparam logic [HEIGHT_REG_W-1:0] MAXH_CMP = HEIGHT_REG_W'(MAX_HEIGHT);

  logic [CW-1:0]    w_last;
  logic [ROW_W-1:0] h_last;

  logic [CW-1:0]    in_col, in_col_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  bank_t            in_bank, in_bank_next;
  logic             in_done, in_done_next;
  logic [CW-1:0]    out_col, out_col_next;
  logic [ROW_W-1:0] out_row, out_row_next;
  bank_t            out_bank, out_bank_next;
  logic             out_done, out_done_next;

  logic [CW-1:0]    oc;
  logic [ROW_W-1:0] orow;
  bank_t            ob;
  logic             od;
  logic [CW-1:0]    need_c;
  logic [ROW_W-1:0] need_r;
  logic             pix_step;
  logic             emit;

  logic [WIDTH_REG_W-1:0]  w_in;
  logic [HEIGHT_REG_W-1:0] h_in;
  logic [CW-1:0]           w_cfg_last;
  logic [ROW_W-1:0]        h_cfg_last;

  // Clamp the written geometry: zero means one, too large saturates
  assign w_in = cfg_data[WIDTH_REG_W-1:0];
  assign h_in = cfg_data[HEIGHT_REG_W-1:0];
  assign w_cfg_last = (w_in == '0) ? '0 :
                      ({1'b0, w_in} > MAXW_CMP) ? CW'(MAX_WIDTH - 1) :
                      CW'(w_in - 1'b1);
  assign h_cfg_last = (h_in == '0) ? '0 :
                      (h_in > MAXH_CMP) ? ROW_W'(MAX_HEIGHT - 1) :
                      ROW_W'(h_in - 1'b1);

  assign pix_step = step && !drain;

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    in_bank_next = in_bank;
    in_done_next = in_done;
    oc   = out_col;
    orow = out_row;
    ob   = out_bank;
    od   = out_done;

    if (pix_step) begin
      // first pixel after a complete frame: drop what is left of the old one
      if (in_done) begin
        oc   = '0;
        orow = '0;
        ob   = '0;
        od   = 1'b0;
      end
      in_done_next = 1'b0;
      if (in_col == w_last) begin
        in_col_next = '0;
        if (in_row == h_last) begin
          in_row_next  = '0;
          in_bank_next = '0;
          in_done_next = 1'b1;
        end else begin
          in_row_next  = in_row + 1'b1;
          in_bank_next = bank_inc(in_bank);
        end
      end else begin
        in_col_next = in_col + 1'b1;
      end
    end

    // last input position the next result depends on
    need_r = (orow == h_last) ? orow : orow + 1'b1;
    need_c = (oc == w_last) ? oc : oc + 1'b1;

    emit = step && !od &&
           (in_done_next || (in_row_next > need_r) ||
            ((in_row_next == need_r) && (in_col_next > need_c)));

    out_col_next  = oc;
    out_row_next  = orow;
    out_bank_next = ob;
    out_done_next = od;
    if (emit) begin
      if (oc == w_last) begin
        out_col_next = '0;
        if (orow == h_last) begin
          out_row_next  = '0;
          out_bank_next = '0;
          out_done_next = 1'b1;
        end else begin
          out_row_next  = orow + 1'b1;
          out_bank_next = bank_inc(ob);
        end
      end else begin
        out_col_next = oc + 1'b1;
      end
    end
  end

  assign wr.wr_en   = pix_step;
  assign wr.wr_bank = in_bank;
  assign wr.pixel   = pixel;
  assign wr_col     = in_col;

  assign rd_col_a = (oc == '0) ? '0 : oc - 1'b1;
  assign rd_col_b = need_c;

  assign rd.emit         = emit;
  assign rd.first_col    = (oc == '0);
  assign rd.end_of_row   = (oc == w_last);
  assign rd.end_of_frame = (oc == w_last) && (orow == h_last);
  assign rd.row_bank[0]  = (orow == '0) ? ob : bank_dec(ob);
  assign rd.row_bank[1]  = ob;
  assign rd.row_bank[2]  = (orow == h_last) ? ob : bank_inc(ob);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last   <= W_LAST_RST;
      h_last   <= H_LAST_RST;
      in_col   <= '0;
      in_row   <= '0;
      in_bank  <= '0;
      in_done  <= 1'b0;
      out_col  <= '0;
      out_row  <= '0;
      out_bank <= '0;
      out_done <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH: begin
          w_last <= w_cfg_last;
        end
        REG_IMAGE_HEIGHT: begin
          h_last <= h_cfg_last;
        end
        default: begin
        end
      endcase
      // restart the frame; line store contents are kept
      in_col   <= '0;
      in_row   <= '0;
      in_bank  <= '0;
      in_done  <= 1'b0;
      out_col  <= '0;
      out_row  <= '0;
      out_bank <= '0;
      out_done <= 1'b0;
    end else if (step) begin
      in_col   <= in_col_next;
      in_row   <= in_row_next;
      in_bank  <= in_bank_next;
      in_done  <= in_done_next;
      out_col  <= out_col_next;
      out_row  <= out_row_next;
      out_bank <= out_bank_next;
      out_done <= out_done_next;
    end
  end

endmodule

// File: rtl/medf3_window.sv
`timescale 1ns / 1ps
// Line store banks, write forwarding and 3x3 window assembly with column sort.
// Depends on medf3_pkg and medf3_ram.
module medf3_window #(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  medf3_pkg::wr_ctl_t   wr,
  input  logic [CW-1:0]        wr_col,
  input  logic [CW-1:0]        rd_col_a,
  input  logic [CW-1:0]        rd_col_b,
  input  medf3_pkg::emit_ctl_t rd,
  input  logic                 shift,
  output medf3_pkg::win_t      sorted
);
  import medf3_pkg::*;

  pix_t  fresh_a [KERNEL];
  pix_t  fresh_b [KERNEL];
  pix_t  wpix;
  bank_t [KERNEL-1:0] row_bank;
  logic  first_col;
  trio_t left, center, right, ctr;

  for (genvar b = 0; b < KERNEL; b++) begin : g_bank
    logic bank_we;
    logic hit_a, hit_b;
    pix_t ram_a, ram_b;

    assign bank_we = wr.wr_en && (wr.wr_bank == bank_t'(b));

    medf3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk     (clk),
      .we      (bank_we),
      .waddr   (wr_col),
      .wdata   (wr.pixel),
      .re      (rd.emit),
      .raddr_a (rd_col_a),
      .raddr_b (rd_col_b),
      .rdata_a (ram_a),
      .rdata_b (ram_b)
    );

    // a pixel written in the read cycle is not in the RAM output yet
    always_ff @(posedge clk) begin
      if (rd.emit) begin
        hit_a <= bank_we && (wr_col == rd_col_a);
        hit_b <= bank_we && (wr_col == rd_col_b);
      end
    end

    assign fresh_a[b] = hit_a ? wpix : ram_a;
    assign fresh_b[b] = hit_b ? wpix : ram_b;
  end

  always_ff @(posedge clk) begin
    if (rd.emit) begin
      wpix      <= wr.pixel;
      row_bank  <= rd.row_bank;
      first_col <= rd.first_col;
    end
    // right column of this result is the center column of the next one
    if (shift) begin
      ctr <= right;
    end
  end

  always_comb begin
    for (int i = 0; i < KERNEL; i++) begin
      case (row_bank[i])
        bank_t'(1): begin
          left[i]  = fresh_a[1];
          right[i] = fresh_b[1];
        end
        bank_t'(2): begin
          left[i]  = fresh_a[2];
          right[i] = fresh_b[2];
        end
        default: begin
          left[i]  = fresh_a[0];
          right[i] = fresh_b[0];
        end
      endcase
      center[i] = first_col ? left[i] : ctr[i];
    end
  end

  assign sorted[0] = sort3(left);
  assign sorted[1] = sort3(center);
  assign sorted[2] = sort3(right);

endmodule

// File: rtl/medf3_median.sv
`timescale 1ns / 1ps
// Second pipeline stage: median of nine from three column-sorted triples.
// Depends on medf3_pkg.
module medf3_median (
  input  logic            clk,
  input  logic            load,
  input  medf3_pkg::win_t sorted,
  output medf3_pkg::pix_t median
);
  import medf3_pkg::*;

  win_t win;

  always_ff @(posedge clk) begin
    if (load) begin
      win <= sorted;
    end
  end

  // max of column minima, median of column medians, min of column maxima
  assign median = med3(max3(win[0][0], win[1][0], win[2][0]),
                       med3(win[0][1], win[1][1], win[2][1]),
                       min3(win[0][2], win[1][2], win[2][2]));

endmodule

// File: rtl/median_filter_3x3.sv
`timescale 1ns / 1ps
// Top level of the streaming 3x3 median filter with replicated borders.
// Depends on medf3_pkg, medf3_ctrl, medf3_window, medf3_median, medf3_ram.
//
//   channel  dir  handshake            word
//   pix      in   pix_valid/pix_stall  in_word_t  {pixel_in, drain}
//   res      out  res_valid/res_stall  out_word_t {pixel_out, end_of_row, end_of_frame}
//   cfg      in   cfg_we               cfg_idx, cfg_data (no read-back)
//
// One pix word per clock while pix_stall is low. A word that produces a result shows
// it in res_word through these registers in order: the line store read registers at
// the accept edge, the column sort feeds the median register, and the median select
// feeds res_word.
// rst is synchronous; the line store is not cleared and needs no clearing pass.
// A stalled res word holds; pix keeps flowing until both inner stages and res fill.
// A cfg write restarts the frame; issue it only while the pipe is empty (not enforced).
module median_filter_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_stall,
  input  medf3_pkg::in_word_t               pix_word,
  output logic                              res_valid,
  input  logic                              res_stall,
  output medf3_pkg::out_word_t              res_word,
  input  logic                              cfg_we,
  input  logic [medf3_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [medf3_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import medf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic          accept;
  logic          s1_valid, s2_valid;
  logic          s1_free, s2_free, res_free;
  logic          s1_adv, s2_adv;
  logic          s1_eor, s1_eof, s2_eor, s2_eof;
  wr_ctl_t       wr;
  emit_ctl_t     rd;
  logic [CW-1:0] wr_col, rd_col_a, rd_col_b;
  win_t          sorted;
  pix_t          median;

  // Collapsing pipeline: each stage moves when the one after it can take it
  assign res_free = !res_valid || !res_stall;
  assign s2_free  = !s2_valid || res_free;
  assign s2_adv   = s2_valid && res_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s1_adv   = s1_valid && s2_free;

  assign pix_stall = !s1_free;
  assign accept    = pix_valid && s1_free;

  medf3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .step     (accept),
    .drain    (pix_word.drain),
    .pixel    (pix_word.pixel_in),
    .wr       (wr),
    .wr_col   (wr_col),
    .rd_col_a (rd_col_a),
    .rd_col_b (rd_col_b),
    .rd       (rd)
  );

  // Stage 1: bank read data, window build, column sort
  medf3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk      (clk),
    .wr       (wr),
    .wr_col   (wr_col),
    .rd_col_a (rd_col_a),
    .rd_col_b (rd_col_b),
    .rd       (rd),
    .shift    (s1_adv),
    .sorted   (sorted)
  );

  // Stage 2: final median select
  medf3_median u_median (
    .clk    (clk),
    .load   (s1_adv),
    .sorted (sorted),
    .median (median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // load stage 1 on a result-producing word, drop it when it moves on
      if (rd.emit) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        res_valid <= 1'b1;
      end else if (res_free) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Row and frame marks ride along with the pixel data
  always_ff @(posedge clk) begin
    if (rd.emit) begin
      s1_eor <= rd.end_of_row;
      s1_eof <= rd.end_of_frame;
    end
    if (s1_adv) begin
      s2_eor <= s1_eor;
      s2_eof <= s1_eof;
    end
    if (s2_adv) begin
      res_word.pixel_out    <= median;
      res_word.end_of_row   <= s2_eor;
      res_word.end_of_frame <= s2_eof;
    end
  end

  // A new result never lands on a stage 1 entry that is still held
  a_s1_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rd.emit |-> (!s1_valid || s1_adv))
    else $error("stage 1 overwritten while holding a result");

  // pix stalls only when both inner stages and the res word are full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (s1_valid && s2_valid && res_valid))
    else $error("input stalled with room in the pipeline");

  // A result is produced only for an accepted word
  a_emit_accept: assert property (@(posedge clk) disable iff (rst)
    rd.emit |-> accept)
    else $error("result issued without an accepted word");

  // End of frame always closes a row
  a_eof_row: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.end_of_frame) |-> res_word.end_of_row)
    else $error("end_of_frame without end_of_row");

endmodule
